// File: src/b64d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  localparam int unsigned B64D_FIFO_DEPTH = 4;
  localparam int unsigned B64D_PTR_W      = $clog2(B64D_FIFO_DEPTH);

  localparam int unsigned TOTAL_W = 33;
  localparam int unsigned LIMIT_W = 32;

  // sextet codes beyond the 64 alphabet values
  localparam logic [6:0] SEXTET_PAD = 7'd64;
  localparam logic [6:0] SEXTET_BAD = 7'd127;

  // byte count of a group entry; zero marks a bare end marker
  localparam logic [1:0] COUNT_MARKER = 2'd0;

  typedef struct packed {
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [1:0]         count;
    logic               fin;
    logic [TOTAL_W-1:0] base;
  } b64d_group_t;

endpackage

`default_nettype wire

// File: src/b64d_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           in_char_i,
  input  wire logic                 in_first_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 q_full_i,
  output logic                      q_push_o,
  output b64d_pkg::b64d_group_t     q_entry_o
);
  import b64d_pkg::*;

  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (ch inside {[8'h41:8'h5a]}) begin
        t = ch - 8'h41;
      end else if (ch inside {[8'h61:8'h7a]}) begin
        t = ch - 8'h61 + 8'd26;
      end else if (ch inside {[8'h30:8'h39]}) begin
        t = ch - 8'h30 + 8'd52;
      end else if (ch == 8'h2b) begin
        t = 8'd62;
      end else if (ch == 8'h2f) begin
        t = 8'd63;
      end else if (ch == 8'h3d) begin
        t = {1'b0, SEXTET_PAD};
      end else begin
        t = {1'b0, SEXTET_BAD};
      end
      sextet_of = t[6:0];
    end
  endfunction

  logic [LIMIT_W-1:0] limit_q;
  logic [1:0]         fill_q, fill_d, fill_eff;
  logic [6:0]         held_q [3];
  logic [TOTAL_W-1:0] total_q, total_d, total_eff, sum;
  logic               done_q, done_d, done_eff;
  logic               accept, complete, marker, fin;
  logic [6:0]         v;
  logic [1:0]         count;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // a first character clears the message state before it is handled
  assign fill_eff  = in_first_i ? 2'd0 : fill_q;
  assign total_eff = in_first_i ? '0 : total_q;
  assign done_eff  = in_first_i ? 1'b0 : done_q;

  assign v        = sextet_of(in_char_i);
  assign complete = !done_eff && (v != SEXTET_BAD) && (fill_eff == 2'd3);
  assign marker   = (held_q[0] == SEXTET_PAD) || (held_q[1] == SEXTET_PAD);

  always_comb begin
    if (held_q[2] == SEXTET_PAD) begin
      count = 2'd1;
    end else if (v == SEXTET_PAD) begin
      count = 2'd2;
    end else begin
      count = 2'd3;
    end
  end

  assign sum = total_eff + TOTAL_W'(count);
  assign fin = sum >= {1'b0, limit_q};

  always_comb begin
    q_entry_o.b0    = {held_q[0][5:0], held_q[1][5:4]};
    q_entry_o.b1    = {held_q[1][3:0], held_q[2][5:2]};
    q_entry_o.b2    = {held_q[2][1:0], v[5:0]};
    q_entry_o.count = marker ? COUNT_MARKER : count;
    q_entry_o.fin   = marker | fin;
    q_entry_o.base  = total_eff;
  end

  assign q_push_o = accept && complete;

  always_comb begin
    fill_d  = fill_eff;
    total_d = total_eff;
    done_d  = done_eff;
    if (!done_eff && (v != SEXTET_BAD)) begin
      if (fill_eff != 2'd3) begin
        fill_d = fill_eff + 2'd1;
      end else begin
        fill_d = 2'd0;
        if (marker) begin
          done_d = 1'b1;
        end else begin
          total_d = sum;
          done_d  = fin;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LIMIT_W'(1);
      fill_q    <= 2'd0;
      total_q   <= '0;
      done_q    <= 1'b0;
      held_q[0] <= 7'd0;
      held_q[1] <= 7'd0;
      held_q[2] <= 7'd0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (accept) begin
        fill_q  <= fill_d;
        total_q <= total_d;
        done_q  <= done_d;
        if (!done_eff && (v != SEXTET_BAD) && (fill_eff != 2'd3)) begin
          held_q[fill_eff] <= v;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/b64d_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_fifo (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire b64d_pkg::b64d_group_t  entry_i,
  input  wire logic                   pop_i,
  output b64d_pkg::b64d_group_t       entry_o,
  output logic                        full_o,
  output logic                        empty_o
);
  import b64d_pkg::*;

  b64d_group_t           mem_q [B64D_FIFO_DEPTH];
  logic [B64D_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [B64D_PTR_W:0]   count_q;

  assign full_o  = count_q == (B64D_PTR_W + 1)'(B64D_FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == B64D_PTR_W'(B64D_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == B64D_PTR_W'(B64D_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/b64d_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire b64d_pkg::b64d_group_t  head_i,
  input  wire logic                   empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        out_byte_valid_o,
  output logic                        out_last_o,
  output logic                        out_finished_o,
  output logic [32:0]                 out_total_o
);
  import b64d_pkg::*;

  logic               valid_q;
  logic [1:0]         k_q;
  logic               load, is_marker, is_last;
  logic [7:0]         byte_q, byte_d;
  logic               bvalid_q, last_q, fin_q;
  logic [TOTAL_W-1:0] total_q, total_d;

  assign load      = (!valid_q || out_ready_i) && !empty_i;
  assign is_marker = head_i.count == COUNT_MARKER;
  assign is_last   = is_marker || (k_q == head_i.count - 2'd1);
  assign pop_o     = load && is_last;

  always_comb begin
    case (k_q)
      2'd0:    byte_d = head_i.b0;
      2'd1:    byte_d = head_i.b1;
      default: byte_d = head_i.b2;
    endcase
    if (is_marker) begin
      byte_d  = 8'd0;
      total_d = head_i.base;
    end else begin
      total_d = head_i.base + TOTAL_W'(k_q) + TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        k_q     <= is_last ? 2'd0 : k_q + 2'd1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      bvalid_q <= !is_marker;
      last_q   <= is_last;
      fin_q    <= is_last && head_i.fin;
      total_q  <= total_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign out_byte_o       = byte_q;
  assign out_byte_valid_o = bvalid_q;
  assign out_last_o       = last_q;
  assign out_finished_o   = fin_q;
  assign out_total_o      = total_q;

endmodule

`default_nettype wire

// File: src/base64_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Base-64 text decoder on streaming channels.
// Slave side: one character per request, tuser[0] flags the first character
// of a message. Non-alphabet characters are dropped, '=' is padding; every
// fourth valid character closes a group that yields one to three bytes, or
// a bare end marker (tuser[0] low) for padding in the first two places.
// Master side: one result per request; tlast marks the final result of the
// closing character, tuser[1] marks the end of the message by padding or
// by the byte limit, tdata carries the byte and the running total.
// Config channel: writes the byte limit; ready is always high, writes are
// expected only while the block is idle.
// Throughput: one character per cycle while the group queue is not full.
// A closing group passes through the queue to the output register; further
// results follow one per cycle from it while the receiver is ready.
// A four-entry group queue sits between the classifier and the output
// sequencer, so a stalled receiver back-pressures the input only once the
// queue is full. Reset clears all message state and sets the limit to one.
module base64_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] text_char
  input  wire logic [0:0]  s_axis_tuser,  // [0] first_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // [7:0] out_byte, [40:8] total_bytes
  output logic [1:0]       m_axis_tuser,  // [0] byte_valid, [1] finished
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);
  import b64d_pkg::*;

  b64d_group_t push_entry, head_entry;
  logic        push, pop, full, empty;
  logic [7:0]  out_byte;
  logic [32:0] out_total;

  assign cfg_ready_o = 1'b1;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_char_i   (s_axis_tdata),
    .in_first_i  (s_axis_tuser[0]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (full),
    .q_push_o    (push),
    .q_entry_o   (push_entry)
  );

  b64d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  b64d_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head_entry),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_byte_o       (out_byte),
    .out_byte_valid_o (m_axis_tuser[0]),
    .out_last_o       (m_axis_tlast),
    .out_finished_o   (m_axis_tuser[1]),
    .out_total_o      (out_total)
  );

  assign m_axis_tdata = {7'd0, out_total, out_byte};

endmodule

`default_nettype wire

// File: src/b64d_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module b64d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // end of message is always the final result of its character
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("finished without last");

  // bare end marker closes the message and stands alone
  a_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && m_axis_tuser[1])
    else $error("malformed end marker");

  a_marker_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("end marker carries data");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
